/* hw/rtl/irc_pkg.sv */
`default_nettype none

package irc_pkg;

    localparam int POS_W = 5;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] MAGIC_WORD = 16'h4758;
    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  BYTE_COUNT = 8'd26;

    // byte positions inside the 31-byte reply
    localparam logic [POS_W-1:0] POS_ADDR       = 5'd0;
    localparam logic [POS_W-1:0] POS_FUNC       = 5'd1;
    localparam logic [POS_W-1:0] POS_COUNT      = 5'd2;
    localparam logic [POS_W-1:0] POS_MAGIC_HI   = 5'd3;
    localparam logic [POS_W-1:0] POS_MAGIC_LO   = 5'd4;
    localparam logic [POS_W-1:0] POS_VER_HI     = 5'd5;
    localparam logic [POS_W-1:0] POS_VER_LO     = 5'd6;
    localparam logic [POS_W-1:0] POS_KIND_HI    = 5'd7;
    localparam logic [POS_W-1:0] POS_KIND_LO    = 5'd8;
    localparam logic [POS_W-1:0] POS_STAT_HI    = 5'd9;
    localparam logic [POS_W-1:0] POS_STAT_LO    = 5'd10;
    localparam logic [POS_W-1:0] POS_DRV_HI     = 5'd13;
    localparam logic [POS_W-1:0] POS_DRV_LO     = 5'd14;
    localparam logic [POS_W-1:0] POS_ID_FIRST   = 5'd17;
    localparam logic [POS_W-1:0] POS_ID_LAST    = 5'd24;
    localparam logic [POS_W-1:0] POS_TRAILER_LO = 5'd29;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd30;

    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_CRC    = 2'd1,
        VERDICT_HEADER = 2'd2,
        VERDICT_MAGIC  = 2'd3
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  node_address;
        logic [15:0] map_version;
        logic [15:0] node_kind;
        logic [15:0] node_status;
        logic [15:0] driver_number;
        logic [63:0] unique_id;
    } t_result;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/irc_frame.sv */
`default_nettype none

module irc_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_start,
    input  wire logic [7:0]       i_addr,
    output      logic             o_last,
    output      irc_pkg::t_result o_result
);

    logic                          r_active;
    logic [irc_pkg::POS_W-1:0]     r_pos;
    logic [15:0]                   r_crc;
    logic [7:0]                    r_addr;
    logic                          r_hdr_bad;
    logic                          r_magic_bad;
    logic [15:0]                   r_map_version;
    logic [15:0]                   r_node_kind;
    logic [15:0]                   r_node_status;
    logic [15:0]                   r_driver_number;
    logic [63:0]                   r_id;
    logic [7:0]                    r_trailer_low;

    logic                          w_active;
    logic                          w_update;
    logic [irc_pkg::POS_W-1:0]     w_pos;
    logic [15:0]                   w_crc;
    logic [7:0]                    w_addr;
    logic                          w_hdr_err;
    logic                          w_magic_err;
    logic [15:0]                   w_rx_crc;
    irc_pkg::t_verdict             w_verdict;

    logic [irc_pkg::POS_W-1:0]     n_pos;
    logic [15:0]                   n_crc;
    logic                          n_hdr_bad;
    logic                          n_magic_bad;

    // a start byte is byte 0 of a fresh frame
    always_comb begin
        w_active = i_start || r_active;
        w_pos    = i_start ? '0 : r_pos;
        w_crc    = i_start ? irc_pkg::CRC_INIT : r_crc;
        w_addr   = i_start ? i_addr : r_addr;
        w_update = i_fire && w_active;
        o_last   = w_active && (w_pos == irc_pkg::POS_LAST);
    end

    always_comb begin
        w_hdr_err   = ((w_pos == irc_pkg::POS_ADDR)  && (i_byte != w_addr)) ||
                      ((w_pos == irc_pkg::POS_FUNC)  && (i_byte != irc_pkg::FUNC_READ)) ||
                      ((w_pos == irc_pkg::POS_COUNT) && (i_byte != irc_pkg::BYTE_COUNT));
        w_magic_err = ((w_pos == irc_pkg::POS_MAGIC_HI) && (i_byte != irc_pkg::MAGIC_WORD[15:8])) ||
                      ((w_pos == irc_pkg::POS_MAGIC_LO) && (i_byte != irc_pkg::MAGIC_WORD[7:0]));
        n_hdr_bad   = (!i_start && r_hdr_bad) || w_hdr_err;
        n_magic_bad = (!i_start && r_magic_bad) || w_magic_err;
        n_crc       = (w_pos < irc_pkg::POS_TRAILER_LO) ? irc_pkg::crc_byte(w_crc, i_byte) : w_crc;
        n_pos       = o_last ? '0 : w_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_crc       <= irc_pkg::CRC_INIT;
            r_addr      <= '0;
            r_hdr_bad   <= 1'b0;
            r_magic_bad <= 1'b0;
        end else if (w_update) begin
            r_active    <= !o_last;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_addr      <= w_addr;
            r_hdr_bad   <= n_hdr_bad;
            r_magic_bad <= n_magic_bad;
        end
    end

    // field words are fully rewritten before the last byte, so no clear on start
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            if (w_pos == irc_pkg::POS_VER_HI || w_pos == irc_pkg::POS_VER_LO) begin
                r_map_version <= {r_map_version[7:0], i_byte};
            end
            if (w_pos == irc_pkg::POS_KIND_HI || w_pos == irc_pkg::POS_KIND_LO) begin
                r_node_kind <= {r_node_kind[7:0], i_byte};
            end
            if (w_pos == irc_pkg::POS_STAT_HI || w_pos == irc_pkg::POS_STAT_LO) begin
                r_node_status <= {r_node_status[7:0], i_byte};
            end
            if (w_pos == irc_pkg::POS_DRV_HI || w_pos == irc_pkg::POS_DRV_LO) begin
                r_driver_number <= {r_driver_number[7:0], i_byte};
            end
            if (w_pos >= irc_pkg::POS_ID_FIRST && w_pos <= irc_pkg::POS_ID_LAST) begin
                r_id <= {r_id[55:0], i_byte};
            end
            if (w_pos == irc_pkg::POS_TRAILER_LO) begin
                r_trailer_low <= i_byte;
            end
        end
    end

    // CRC mismatch outranks header, header outranks magic
    always_comb begin
        w_rx_crc = {i_byte, r_trailer_low};
        priority if (w_rx_crc != r_crc) begin
            w_verdict = irc_pkg::VERDICT_CRC;
        end else if (r_hdr_bad) begin
            w_verdict = irc_pkg::VERDICT_HEADER;
        end else if (r_magic_bad) begin
            w_verdict = irc_pkg::VERDICT_MAGIC;
        end else begin
            w_verdict = irc_pkg::VERDICT_OK;
        end
    end

    always_comb begin
        o_result              = '0;
        o_result.verdict      = w_verdict;
        o_result.node_address = r_addr;
        if (w_verdict == irc_pkg::VERDICT_OK) begin
            o_result.map_version   = r_map_version;
            o_result.node_kind     = r_node_kind;
            o_result.node_status   = r_node_status;
            o_result.driver_number = r_driver_number;
            o_result.unique_id     = r_id;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/irc_out_reg.sv */
`default_nettype none

module irc_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire irc_pkg::t_result i_result,
    input  wire logic             i_stall,
    output      logic             o_valid,
    output      logic             o_free,
    output      irc_pkg::t_result o_result
);

    logic             r_valid;
    irc_pkg::t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/identity_response_checker.sv */
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_stall  | data_byte, frame_start, expected_address
// out     | output    | o_out_valid / i_out_stall| verdict, node_address, id fields
//
// One byte item per cycle unless the input is stalled: input register, one CRC byte
// update plus compares, then the result register. Byte 30 passes both
// registers before its verdict leaves. Synchronous active-low reset
// empties both registers and drops any partial frame. A stalled output holds
// its verdict; the input side stalls only while byte 30 waits on a held result register.
`default_nettype none

module identity_response_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_start,
    input  wire logic [7:0]  i_expected_address,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_verdict,
    output      logic [7:0]  o_node_address,
    output      logic [15:0] o_map_version,
    output      logic [15:0] o_node_kind,
    output      logic [15:0] o_node_status,
    output      logic [15:0] o_driver_number,
    output      logic [63:0] o_unique_id
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    logic [7:0]       r_in_addr;
    logic             n_in_valid;

    logic             w_accept;
    logic             w_consume;
    logic             w_last;
    logic             w_load;
    logic             w_out_free;
    irc_pkg::t_result w_result;
    irc_pkg::t_result w_out;

    // the item in the input register moves on unless it ends a frame
    // and the result register is still held
    assign w_consume  = r_in_valid && (!w_last || w_out_free);
    assign w_load     = w_consume && w_last;
    assign o_in_stall = r_in_valid && !w_consume;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_in_valid = w_accept || (r_in_valid && !w_consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_frame_start;
            r_in_addr  <= i_expected_address;
        end
    end

    irc_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_consume),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .i_addr   (r_in_addr),
        .o_last   (w_last),
        .o_result (w_result)
    );

    irc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (w_out_free),
        .o_result (w_out)
    );

    assign o_verdict       = w_out.verdict;
    assign o_node_address  = w_out.node_address;
    assign o_map_version   = w_out.map_version;
    assign o_node_kind     = w_out.node_kind;
    assign o_node_status   = w_out.node_status;
    assign o_driver_number = w_out.driver_number;
    assign o_unique_id     = w_out.unique_id;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a held verdict");

    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("unconsumed input item lost");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict != irc_pkg::VERDICT_OK)) |->
        (o_unique_id == '0 && o_map_version == '0 && o_driver_number == '0))
        else $error("fields not cleared on failed verdict");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
